/* design/gld_pkg.sv */
// ----------------------------------------------------------------------------
// gld_pkg
// Shared constants and types for the GIF LZW decoder unit.
// ----------------------------------------------------------------------------
package gld_pkg;

    localparam int MAX_CODE_BITS     = 12;
    localparam int DICT_DEPTH        = 4096;
    localparam int ADDR_W            = 12;
    localparam int PIXELS_PER_RESULT = 64;
    localparam int MAX_RESULTS       = 60;
    localparam int PIX_CAP           = MAX_RESULTS * PIXELS_PER_RESULT;
    localparam int QUEUE_DEPTH       = 8;
    localparam logic [3:0] ROOT_RESET = 4'd8;
    localparam logic [3:0] ROOT_MIN   = 4'd2;
    localparam logic [3:0] ROOT_MAX   = 4'd8;

    // Write request into the prefix/suffix dictionary
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] prefix;
        logic [7:0]        suffix;
    } dict_wr_t;

    // One parsed code waiting to be expanded
    typedef struct packed {
        logic              first;   // first code after a clear
        logic [ADDR_W-1:0] code;
        logic [12:0]       ns;      // next slot when the code was parsed
        logic              add;     // a dictionary entry is added
    } code_entry_t;

endpackage

/* design/gld_dict_ram.sv */
// ----------------------------------------------------------------------------
// gld_dict_ram
// Prefix and suffix dictionary: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gld_dict_ram import gld_pkg::*; (
    input  logic              aclk,
    input  logic [ADDR_W-1:0] rd_addr,
    input  dict_wr_t          wr,
    output logic [ADDR_W-1:0] rd_prefix,
    output logic [7:0]        rd_suffix
);

    logic [ADDR_W-1:0] prefix_mem [DICT_DEPTH];
    logic [7:0]        suffix_mem [DICT_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            prefix_mem[wr.addr] <= wr.prefix;
            suffix_mem[wr.addr] <= wr.suffix;
        end
        rd_prefix <= prefix_mem[rd_addr];
        rd_suffix <= suffix_mem[rd_addr];
    end

endmodule

/* design/gif_lzw_decoder_unit.sv */
// ----------------------------------------------------------------------------
// gif_lzw_decoder_unit
// GIF image-data LZW decoder, one stream byte per input transaction.
// ----------------------------------------------------------------------------
// Each accepted byte is handled to completion before the next is taken. A
// length byte or an ignored byte goes straight to its final result. A data
// byte first parses each code it completes (up to 6), then per code walks
// the dictionary chain one read at a time (registered dictionary read) and
// pops the string from the stack, one pixel per pop. Every 64 pixels leave
// as one result; the final result of a byte has tlast set and carries the
// status after that byte. Output back-pressure stalls the pixel pop. No
// clearing pass is needed after reset.
module gif_lzw_decoder_unit import gld_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_data,      // root_bits
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,       // [7:0] stream_byte
    input  logic         s_tuser,       // [0] new_image
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [535:0] m_tdata,       // [511:0] pixels_0..63, [518:512] pixel_count,
                                        // [534:519] bad_code_total, [535] zero
    output logic         m_tlast,       // last_of_run
    output logic         m_tuser        // [0] image_ended
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PARSE, ST_DEC, ST_WALK_RD, ST_WALK_DATA, ST_POP_RD, ST_POP_WR, ST_DONE
    } state_t;

    state_t            state_reg;
    logic [3:0]        root_cfg_reg, act_root_reg, width_reg;
    logic [12:0]       limit_reg, slot_reg;
    logic [ADDR_W-1:0] old_reg, code_reg, cnew_reg;
    logic [7:0]        first_reg, left_reg;
    logic [19:0]       acc_reg;
    logic [4:0]        bits_reg;
    logic [15:0]       bad_reg;
    logic              ended_reg, aclear_reg;
    code_entry_t       q_reg [QUEUE_DEPTH];
    logic [2:0]        q_cnt_reg, q_idx_reg;
    logic [12:0]       sp_reg;
    logic [11:0]       pixn_reg;
    logic [511:0]      chunk_reg;
    logic [6:0]        cnt_reg;
    logic              m_valid_reg, m_last_reg;
    logic [511:0]      m_pix_reg;
    logic [6:0]        m_cnt_reg;
    logic [15:0]       m_bad_reg;
    logic              m_ended_reg;

    logic [7:0]        stack_mem [DICT_DEPTH];
    logic [7:0]        stack_rd_reg;

    // Combinational helpers
    logic [12:0]       clear_code, first_new;
    logic [3:0]        root_clamped;
    logic [11:0]       width_mask, pc;
    logic              parse_go, walk_go, out_free, m_load;
    code_entry_t       cur;
    logic [12:0]       sp_m1, slot_inc;
    logic              stk_we;
    logic [11:0]       stk_waddr;
    logic [7:0]        stk_wdata;
    dict_wr_t          dict_wr;
    logic [ADDR_W-1:0] rd_prefix;
    logic [7:0]        rd_suffix;
    logic [511:0]      chunk_ins;

    assign root_clamped = (root_cfg_reg < ROOT_MIN) ? ROOT_MIN :
                          (root_cfg_reg > ROOT_MAX) ? ROOT_MAX : root_cfg_reg;
    assign clear_code = 13'd1 << act_root_reg;
    assign first_new  = clear_code + 13'd2;
    assign width_mask = 12'((13'd1 << width_reg) - 13'd1);
    assign pc         = acc_reg[11:0] & width_mask;
    assign parse_go   = (bits_reg >= {1'b0, width_reg}) && !ended_reg;
    assign cur        = q_reg[q_idx_reg];
    assign walk_go    = ({1'b0, code_reg} >= first_new) && (sp_reg < 13'd4096);
    assign out_free   = !m_valid_reg || m_tready;
    assign sp_m1      = sp_reg - 13'd1;
    assign slot_inc   = slot_reg + 13'd1;

    // Load the output register with a full chunk or with the final result
    assign m_load = out_free && ((state_reg == ST_DONE) ||
                    ((state_reg == ST_POP_WR) && (pixn_reg < 12'(PIX_CAP)) &&
                     (cnt_reg == 7'(PIXELS_PER_RESULT))));

    assign cfg_ready = aresetn;
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tlast   = m_last_reg;
    assign m_tuser   = m_ended_reg;
    assign m_tdata   = {1'b0, m_bad_reg, m_cnt_reg, m_pix_reg};

    // Place the popped pixel at the fill position of the chunk
    always_comb begin
        chunk_ins = chunk_reg;
        for (int i = 0; i < PIXELS_PER_RESULT; i++) begin
            if (cnt_reg[5:0] == 6'(i)) chunk_ins[i*8 +: 8] = stack_rd_reg;
        end
    end

    // Stack and dictionary write ports
    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = sp_reg[11:0];
        stk_wdata = code_reg[7:0];
        dict_wr   = '{en: 1'b0, addr: cur.ns[11:0], prefix: old_reg, suffix: code_reg[7:0]};
        unique case (state_reg)
            ST_DEC: begin
                if (q_idx_reg != q_cnt_reg) begin
                    stk_waddr = 12'd0;
                    if (cur.first) begin
                        stk_we    = 1'b1;
                        stk_wdata = cur.code[7:0];
                    end else if ({1'b0, cur.code} >= cur.ns) begin
                        stk_we    = 1'b1;
                        stk_wdata = first_reg;
                    end
                end
            end
            ST_WALK_RD: begin
                if (!walk_go) begin
                    stk_we     = (sp_reg < 13'd4096);
                    dict_wr.en = cur.add;
                end
            end
            ST_WALK_DATA: begin
                stk_we    = 1'b1;
                stk_wdata = rd_suffix;
            end
            default: ;
        endcase
    end

    // Write the string stack, and hold the popped pixel until the chunk takes it
    always_ff @(posedge aclk) begin
        if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
        if (state_reg == ST_POP_RD) stack_rd_reg <= stack_mem[sp_m1[11:0]];
    end

    gld_dict_ram u_dict (
        .aclk      (aclk),
        .rd_addr   (code_reg),
        .wr        (dict_wr),
        .rd_prefix (rd_prefix),
        .rd_suffix (rd_suffix)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            root_cfg_reg <= ROOT_RESET;
            act_root_reg <= ROOT_RESET;
            width_reg    <= ROOT_RESET + 4'd1;
            limit_reg    <= 13'd1 << (ROOT_RESET + 4'd1);
            slot_reg     <= (13'd1 << ROOT_RESET) + 13'd2;
            old_reg      <= '0;
            first_reg    <= '0;
            acc_reg      <= '0;
            bits_reg     <= '0;
            left_reg     <= '0;
            bad_reg      <= '0;
            ended_reg    <= 1'b0;
            aclear_reg   <= 1'b0;
            q_cnt_reg    <= '0;
            q_idx_reg    <= '0;
            sp_reg       <= '0;
            pixn_reg     <= '0;
            chunk_reg    <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_last_reg   <= 1'b0;
        end else begin
            if (cfg_valid) root_cfg_reg <= cfg_data;
            if (m_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        q_cnt_reg <= '0;
                        pixn_reg  <= '0;
                        state_reg <= ST_DONE;
                        if (s_tuser) begin
                            act_root_reg <= root_clamped;
                            width_reg    <= root_clamped + 4'd1;
                            limit_reg    <= 13'd1 << (root_clamped + 4'd1);
                            slot_reg     <= (13'd1 << root_clamped) + 13'd2;
                            old_reg      <= '0;
                            first_reg    <= '0;
                            acc_reg      <= '0;
                            bits_reg     <= '0;
                            bad_reg      <= '0;
                            aclear_reg   <= 1'b0;
                            left_reg     <= s_tdata;
                            ended_reg    <= (s_tdata == 8'd0);
                        end else if (ended_reg) begin
                            // drop bytes after the end of the image
                        end else if (left_reg == 8'd0) begin
                            left_reg  <= s_tdata;
                            ended_reg <= (s_tdata == 8'd0);
                        end else begin
                            left_reg  <= left_reg - 8'd1;
                            acc_reg   <= acc_reg | 20'({12'd0, s_tdata} << bits_reg);
                            bits_reg  <= bits_reg + 5'd8;
                            state_reg <= ST_PARSE;
                        end
                    end
                end

                ST_PARSE: begin
                    if (parse_go) begin
                        acc_reg  <= acc_reg >> width_reg;
                        bits_reg <= bits_reg - {1'b0, width_reg};
                        if ({1'b0, pc} == clear_code) begin
                            width_reg  <= act_root_reg + 4'd1;
                            limit_reg  <= 13'd1 << (act_root_reg + 4'd1);
                            slot_reg   <= first_new;
                            aclear_reg <= 1'b1;
                        end else if ({1'b0, pc} == clear_code + 13'd1) begin
                            ended_reg <= 1'b1;
                        end else if (aclear_reg) begin
                            aclear_reg <= 1'b0;
                            q_reg[q_cnt_reg] <= '{first: 1'b1,
                                code: ({1'b0, pc} >= slot_reg) ? 12'd0 : pc,
                                ns: slot_reg, add: 1'b0};
                            q_cnt_reg <= q_cnt_reg + 3'd1;
                        end else begin
                            if ({1'b0, pc} > slot_reg && bad_reg != 16'hFFFF)
                                bad_reg <= bad_reg + 16'd1;
                            q_reg[q_cnt_reg] <= '{first: 1'b0, code: pc, ns: slot_reg,
                                add: (slot_reg < limit_reg)};
                            q_cnt_reg <= q_cnt_reg + 3'd1;
                            if (slot_reg < limit_reg) begin
                                slot_reg <= slot_inc;
                                if (slot_inc >= limit_reg && width_reg < 4'(MAX_CODE_BITS)) begin
                                    limit_reg <= limit_reg << 1;
                                    width_reg <= width_reg + 4'd1;
                                end
                            end else if (width_reg < 4'(MAX_CODE_BITS)) begin
                                limit_reg <= limit_reg << 1;
                                width_reg <= width_reg + 4'd1;
                            end
                        end
                    end else begin
                        q_idx_reg <= '0;
                        state_reg <= (q_cnt_reg != 3'd0) ? ST_DEC : ST_DONE;
                    end
                end

                ST_DEC: begin
                    if (q_idx_reg == q_cnt_reg) begin
                        state_reg <= ST_DONE;
                    end else if (cur.first) begin
                        old_reg   <= cur.code;
                        first_reg <= cur.code[7:0];
                        sp_reg    <= 13'd1;
                        q_idx_reg <= q_idx_reg + 3'd1;
                        state_reg <= ST_POP_RD;
                    end else begin
                        // KwKwK or bad code: expand the previous string plus its head
                        if ({1'b0, cur.code} >= cur.ns) begin
                            sp_reg   <= 13'd1;
                            code_reg <= old_reg;
                            cnew_reg <= cur.ns[11:0];
                        end else begin
                            sp_reg   <= 13'd0;
                            code_reg <= cur.code;
                            cnew_reg <= cur.code;
                        end
                        state_reg <= ST_WALK_RD;
                    end
                end

                ST_WALK_RD: begin
                    if (walk_go) begin
                        state_reg <= ST_WALK_DATA;
                    end else begin
                        if (sp_reg < 13'd4096) sp_reg <= sp_reg + 13'd1;
                        if (cur.add) begin
                            first_reg <= code_reg[7:0];
                            old_reg   <= cnew_reg;
                        end
                        q_idx_reg <= q_idx_reg + 3'd1;
                        state_reg <= ST_POP_RD;
                    end
                end

                ST_WALK_DATA: begin
                    sp_reg    <= sp_reg + 13'd1;
                    code_reg  <= rd_prefix;
                    state_reg <= ST_WALK_RD;
                end

                ST_POP_RD: begin
                    if (sp_reg == 13'd0) begin
                        state_reg <= ST_DEC;
                    end else begin
                        sp_reg    <= sp_m1;
                        state_reg <= ST_POP_WR;
                    end
                end

                ST_POP_WR: begin
                    if (pixn_reg >= 12'(PIX_CAP)) begin
                        state_reg <= ST_POP_RD;
                    end else if (cnt_reg == 7'(PIXELS_PER_RESULT)) begin
                        // flush the full chunk before taking this pixel
                        if (out_free) begin
                            m_last_reg  <= 1'b0;
                            m_pix_reg   <= chunk_reg;
                            m_cnt_reg   <= cnt_reg;
                            m_bad_reg   <= bad_reg;
                            m_ended_reg <= ended_reg;
                            chunk_reg   <= {504'd0, stack_rd_reg};
                            cnt_reg     <= 7'd1;
                            pixn_reg    <= pixn_reg + 12'd1;
                            state_reg   <= ST_POP_RD;
                        end
                    end else begin
                        chunk_reg <= chunk_ins;
                        cnt_reg   <= cnt_reg + 7'd1;
                        pixn_reg  <= pixn_reg + 12'd1;
                        state_reg <= ST_POP_RD;
                    end
                end

                ST_DONE: begin
                    if (out_free) begin
                        m_last_reg  <= 1'b1;
                        m_pix_reg   <= chunk_reg;
                        m_cnt_reg   <= cnt_reg;
                        m_bad_reg   <= bad_reg;
                        m_ended_reg <= ended_reg;
                        chunk_reg   <= '0;
                        cnt_reg     <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_idle_chunk_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (cnt_reg == 7'd0))
        else $error("chunk not empty while waiting for a byte");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= 13'd4096)
        else $error("string stack overflow");

    a_walk_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK_DATA) |-> ($past(state_reg) == ST_WALK_RD))
        else $error("dictionary data used without a read");

    a_chunk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 7'(PIXELS_PER_RESULT))
        else $error("chunk overfilled");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= 3'd6)
        else $error("too many codes from one byte");

endmodule
